@@ sv/akct_pkg.sv @@
// Package: sizes, request codes and transaction types for the aging keyed cache table.
package akct_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [7:0] HOLD_RESET = 8'd8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic        inserted;
        logic        full_miss;
        logic        evicted;
        logic [15:0] handle;
        logic [4:0]  count;
    } t_rsp;

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  life;
        logic [15:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ sv/akct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module akct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/aging_keyed_cache_table.sv @@
// Top level: ordered keyed table with lookup/insert, aging tick with eviction, and clear.
// Lookup scans entries in order, refreshes the life of a hit, inserts on a miss if there
// is room. Tick ages entries up to the first with life zero and evicts that one (entry
// scan, then one read and one write per entry moved up). Clear empties the table; an
// unused code only reports the count. One transaction at a time (busy), start taken only
// in idle. Synchronous reset empties the table and sets the hold value to 8.
module aging_keyed_cache_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  akct_pkg::t_req i_req,
    output logic          o_done,
    output akct_pkg::t_rsp o_rsp,
    input  logic          i_cfg_wr_en,
    input  logic [7:0]    i_cfg_wr_data
);
    import akct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CHK,
        S_TK_RD,
        S_TK_CHK,
        S_MV_RD,
        S_MV_WR
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [15:0] r_next_handle;
    logic [7:0]  r_hold;
    logic [63:0] r_key;
    logic        r_done;
    t_rsp        r_rsp;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [AW-1:0] w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry        w_rd;
    logic [CW:0]   w_idx_inc;
    logic          w_at_end;
    logic          w_full;

    assign w_rd      = w_rdata;
    assign w_idx_inc = {1'b0, r_idx} + 1'b1;
    assign w_at_end  = (r_idx == r_count);
    assign w_full    = (r_count == CW'(DEPTH));

    akct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = w_rd;
        w_raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_LK_RD: begin
                if (w_at_end && !w_full) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[AW-1:0];
                    w_wdata = '{key: r_key, life: r_hold, handle: r_next_handle};
                end
            end
            S_LK_CHK: begin
                if (w_rd.key == r_key) begin
                    w_we    = 1'b1;
                    w_wdata = '{key: w_rd.key, life: r_hold, handle: w_rd.handle};
                end
            end
            S_TK_CHK: begin
                if (w_rd.life != 8'd0) begin
                    w_we    = 1'b1;
                    w_wdata = '{key: w_rd.key, life: w_rd.life - 8'd1, handle: w_rd.handle};
                end
            end
            S_MV_RD: begin
                w_raddr = w_idx_inc[AW-1:0];
            end
            S_MV_WR: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_idx         <= '0;
            r_next_handle <= '0;
            r_hold        <= HOLD_RESET;
            r_done        <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_wr_en) begin
                r_hold <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_key <= i_req.key;
                        r_idx <= '0;
                        case (i_req.req_type)
                            REQ_LOOKUP: r_state <= S_LK_RD;
                            REQ_TICK:   r_state <= S_TK_RD;
                            REQ_CLEAR: begin
                                r_count <= '0;
                                r_done  <= 1'b1;
                                r_rsp   <= '0;
                            end
                            default: begin
                                r_done <= 1'b1;
                                r_rsp  <= '{hit: 1'b0, inserted: 1'b0, full_miss: 1'b0,
                                            evicted: 1'b0, handle: 16'd0,
                                            count: 5'(r_count)};
                            end
                        endcase
                    end
                end
                S_LK_RD: begin
                    if (w_at_end) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                        if (w_full) begin
                            r_rsp <= '{hit: 1'b0, inserted: 1'b0, full_miss: 1'b1,
                                       evicted: 1'b0, handle: 16'd0,
                                       count: 5'(r_count)};
                        end else begin
                            r_count       <= r_count + 1'b1;
                            r_next_handle <= r_next_handle + 16'd1;
                            r_rsp <= '{hit: 1'b0, inserted: 1'b1, full_miss: 1'b0,
                                       evicted: 1'b0, handle: r_next_handle,
                                       count: 5'(r_count + 1'b1)};
                        end
                    end else begin
                        r_state <= S_LK_CHK;
                    end
                end
                S_LK_CHK: begin
                    if (w_rd.key == r_key) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                        r_rsp   <= '{hit: 1'b1, inserted: 1'b0, full_miss: 1'b0,
                                     evicted: 1'b0, handle: w_rd.handle,
                                     count: 5'(r_count)};
                    end else begin
                        r_idx   <= w_idx_inc[CW-1:0];
                        r_state <= S_LK_RD;
                    end
                end
                S_TK_RD: begin
                    if (w_at_end) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                        r_rsp   <= '{hit: 1'b0, inserted: 1'b0, full_miss: 1'b0,
                                     evicted: 1'b0, handle: 16'd0,
                                     count: 5'(r_count)};
                    end else begin
                        r_state <= S_TK_CHK;
                    end
                end
                S_TK_CHK: begin
                    if (w_rd.life == 8'd0) begin
                        r_rsp.handle <= w_rd.handle;
                        r_state      <= S_MV_RD;
                    end else begin
                        r_idx   <= w_idx_inc[CW-1:0];
                        r_state <= S_TK_RD;
                    end
                end
                S_MV_RD: begin
                    if (w_idx_inc >= {1'b0, r_count}) begin
                        r_count         <= r_count - 1'b1;
                        r_state         <= S_IDLE;
                        r_done          <= 1'b1;
                        r_rsp.hit       <= 1'b0;
                        r_rsp.inserted  <= 1'b0;
                        r_rsp.full_miss <= 1'b0;
                        r_rsp.evicted   <= 1'b1;
                        r_rsp.count     <= 5'(r_count - 1'b1);
                    end else begin
                        r_state <= S_MV_WR;
                    end
                end
                S_MV_WR: begin
                    r_idx   <= w_idx_inc[CW-1:0];
                    r_state <= S_MV_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds table depth");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0({o_rsp.hit, o_rsp.inserted, o_rsp.full_miss, o_rsp.evicted}))
        else $error("more than one outcome flag in a result");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.hit && !o_rsp.inserted && !o_rsp.evicted) |-> o_rsp.handle == 16'd0)
        else $error("nonzero handle without hit, insert or eviction");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.inserted) |-> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the table by one");

    a_evict_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.evicted) |-> r_count + 1'b1 == $past(r_count))
        else $error("eviction did not shrink the table by one");
`endif

endmodule

@@ bench/testbench.sv @@
// Testbench for aging_keyed_cache_table: queued stimulus, in-bench table predictor, result checks.
`timescale 1ns / 100ps

module testbench;
    import akct_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ACT_ITEM  = 2'd0;
    localparam logic [1:0] ACT_DRAIN = 2'd1;
    localparam logic [1:0] ACT_CFG   = 2'd2;

    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int POOL          = 24;
    localparam int REFILL_PAIRS  = 8;

    typedef struct packed {
        logic [1:0] kind;
        t_req       req;
        logic [7:0] hold;
        logic [4:0] gap;
    } t_action;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;

    aging_keyed_cache_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req         (i_req),
        .o_done        (o_done),
        .o_rsp         (o_rsp),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Table shadow
    logic [63:0] tbl_key    [DEPTH];
    logic [7:0]  tbl_life   [DEPTH];
    logic [15:0] tbl_handle [DEPTH];
    int          tbl_count = 0;
    logic [15:0] tbl_next_handle = '0;
    logic [7:0]  hold_model = HOLD_RESET;

    int n_hit = 0, n_insert = 0, n_full = 0, n_evict = 0;
    int n_tick = 0, n_clear = 0, n_unused = 0, n_cfg = 0;

    function automatic t_rsp table_step_expected(t_req req);
        t_rsp r;
        bit   done;
        r = '0;
        done = 1'b0;
        case (req.req_type)
            REQ_LOOKUP: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (!done && tbl_key[i] == req.key) begin
                        tbl_life[i] = hold_model;
                        r.hit       = 1'b1;
                        r.handle    = tbl_handle[i];
                        done        = 1'b1;
                        n_hit++;
                    end
                end
                if (!done) begin
                    if (tbl_count >= DEPTH) begin
                        r.full_miss = 1'b1;
                        n_full++;
                    end else begin
                        tbl_key[tbl_count]    = req.key;
                        tbl_life[tbl_count]   = hold_model;
                        tbl_handle[tbl_count] = tbl_next_handle;
                        r.handle              = tbl_next_handle;
                        r.inserted            = 1'b1;
                        tbl_next_handle = tbl_next_handle + 16'd1;
                        tbl_count++;
                        n_insert++;
                    end
                end
            end
            REQ_TICK: begin
                n_tick++;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!done && i < tbl_count) begin
                        if (tbl_life[i] == 8'd0) begin
                            r.evicted = 1'b1;
                            r.handle  = tbl_handle[i];
                            for (int j = i; j + 1 < tbl_count; j++) begin
                                tbl_key[j]    = tbl_key[j + 1];
                                tbl_life[j]   = tbl_life[j + 1];
                                tbl_handle[j] = tbl_handle[j + 1];
                            end
                            tbl_count--;
                            done = 1'b1;
                            n_evict++;
                        end else begin
                            tbl_life[i] = tbl_life[i] - 8'd1;
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                tbl_count = 0;
                n_clear++;
            end
            default: n_unused++;
        endcase
        r.count = tbl_count[4:0];
        return r;
    endfunction

    t_action     act_queue [$];
    t_rsp        rsp_expected [$];
    int          items_sent = 0;
    int          rsp_seen = 0;
    int          err_count = 0;
    int          gap_left = 0;
    bit          gap_armed = 1'b0;
    int          settle = 0;
    logic [63:0] key_pool [POOL];

    // Driver
    always @(posedge i_clk) begin : drive
        t_action    act;
        logic       nx_start;
        logic       nx_wr_en;
        logic [7:0] nx_wr_data;
        t_req       nx_req;
        nx_start   = 1'b0;
        nx_wr_en   = 1'b0;
        nx_wr_data = i_cfg_wr_data;
        nx_req     = i_req;
        if (i_rst_n) begin
            if (start && !busy) begin
                rsp_expected.push_back(table_step_expected(i_req));
                items_sent++;
            end
            nx_start = start && busy;
            if (!nx_start && act_queue.size() != 0) begin
                act = act_queue[0];
                case (act.kind)
                    ACT_ITEM: begin
                        if (!gap_armed) begin
                            gap_left  = act.gap;
                            gap_armed = 1'b1;
                        end
                        if (gap_left != 0) begin
                            gap_left--;
                        end else begin
                            act       = act_queue.pop_front();
                            gap_armed = 1'b0;
                            nx_start  = 1'b1;
                            nx_req    = act.req;
                        end
                    end
                    ACT_DRAIN: begin
                        if (items_sent != rsp_seen)
                            settle = 0;
                        else if (settle < SETTLE_CYCLES)
                            settle++;
                        else begin
                            act    = act_queue.pop_front();
                            settle = 0;
                        end
                    end
                    default: begin
                        act        = act_queue.pop_front();
                        nx_wr_en   = 1'b1;
                        nx_wr_data = act.hold;
                        hold_model = act.hold;
                        n_cfg++;
                    end
                endcase
            end
        end
        start         <= nx_start;
        i_cfg_wr_en   <= nx_wr_en;
        i_cfg_wr_data <= nx_wr_data;
        i_req         <= nx_req;
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            err_count++;
        end
    endtask

    // Monitor
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_expected.size() == 0) begin
                $error("result with no transaction outstanding: %p", o_rsp);
                err_count++;
            end else begin
                want = rsp_expected.pop_front();
                check_field("hit", want.hit, o_rsp.hit);
                check_field("inserted", want.inserted, o_rsp.inserted);
                check_field("full_miss", want.full_miss, o_rsp.full_miss);
                check_field("evicted", want.evicted, o_rsp.evicted);
                check_field("handle", want.handle, o_rsp.handle);
                check_field("count", want.count, o_rsp.count);
                rsp_seen <= rsp_seen + 1;
            end
        end
    end

    task automatic add_item(input logic [1:0] rt, input logic [63:0] k, input int gap);
        t_action a;
        a.kind         = ACT_ITEM;
        a.req.req_type = rt;
        a.req.key      = k;
        a.hold         = '0;
        a.gap          = gap[4:0];
        act_queue.push_back(a);
    endtask

    task automatic add_drain();
        t_action a;
        a      = '0;
        a.kind = ACT_DRAIN;
        act_queue.push_back(a);
    endtask

    task automatic add_cfg(input logic [7:0] hold);
        t_action a;
        a      = '0;
        a.kind = ACT_CFG;
        a.hold = hold;
        add_drain();
        act_queue.push_back(a);
    endtask

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, POOL - 1)];
        return {$urandom, $urandom};
    endfunction

    initial begin : main
        logic [7:0] phase_hold [8];
        logic [1:0] rt;
        int         pick;
        bit         burst;
        phase_hold = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd8, 8'd2, 8'd255, 8'd1};
        phase_hold[4] = 8'($urandom_range(0, 255));

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL; i++) begin
            if (i % 3 == 0)
                key_pool[i] = key_pool[i - 1] ^ (64'd1 << $urandom_range(0, 63));
            else
                key_pool[i] = {$urandom, $urandom};
        end

        // Directed: empty table, ignored code, inserts, hit, fill, full miss, eviction
        add_item(REQ_TICK, '0, $urandom_range(0, 19));
        add_item(REQ_CLEAR, '0, $urandom_range(0, 19));
        add_item(REQ_UNUSED, '1, $urandom_range(0, 19));
        add_item(REQ_LOOKUP, '0, 0);
        add_item(REQ_LOOKUP, '1, 0);
        add_item(REQ_LOOKUP, '0, $urandom_range(0, 19));
        add_item(REQ_LOOKUP, 64'h8000_0000_0000_0001, 0);
        add_item(REQ_LOOKUP, 64'h5555_5555_5555_5555, $urandom_range(0, 19));
        add_item(REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        add_item(REQ_TICK, '1, 0);
        add_item(REQ_UNUSED, '0, 0);
        for (int i = 0; i < 11; i++)
            add_item(REQ_LOOKUP, 64'h100 + i, $urandom_range(0, 3));
        add_item(REQ_LOOKUP, 64'h0123_4567_89AB_CDEF, 0);
        add_item(REQ_LOOKUP, 64'h100 + 10, 0);
        add_cfg(8'd0);
        add_item(REQ_LOOKUP, '0, 0);
        add_item(REQ_TICK, '0, 0);
        add_item(REQ_CLEAR, '0, 0);

        // Insert into an empty table, clear, repeat
        add_cfg(HOLD_RESET);
        for (int i = 0; i < REFILL_PAIRS; i++) begin
            add_item(REQ_LOOKUP, {$urandom, $urandom}, 0);
            add_item(REQ_CLEAR, {$urandom, $urandom}, 0);
        end

        // Random phases
        burst = 1'b0;
        for (int p = 0; p < 8; p++) begin
            add_cfg(phase_hold[p]);
            for (int i = 0; i < 137; i++) begin
                if (i % 32 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                if (i == 70 && p % 2 == 1)
                    add_drain();
                pick = $urandom_range(0, 99);
                if (pick < 56)
                    rt = REQ_LOOKUP;
                else if (pick < 94)
                    rt = REQ_TICK;
                else if (pick < 97)
                    rt = REQ_CLEAR;
                else
                    rt = REQ_UNUSED;
                add_item(rt, pick_key(), burst ? 0 : $urandom_range(0, 19));
            end
        end

        while (act_queue.size() != 0 || start || items_sent != rsp_seen)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (rsp_expected.size() != 0) begin
            $error("%0d expected results never arrived", rsp_expected.size());
            err_count++;
        end
        $display("Ran %0d transactions: %0d hits, %0d inserts, %0d full-table misses,",
                 items_sent, n_hit, n_insert, n_full);
        $display("%0d ticks with %0d evictions, %0d clears, %0d unused codes, %0d hold writes",
                 n_tick, n_evict, n_clear, n_unused, n_cfg);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
